/* hdl/tws_pkg.sv */
package tws_pkg;

	// Drive states of a pin
	localparam logic [1:0] PIN_LOW  = 2'd0;
	localparam logic [1:0] PIN_HIGH = 2'd1;
	localparam logic [1:0] PIN_REL  = 2'd2;

	// Hold classes of a pin event
	localparam logic [1:0] HOLD_SETTLE = 2'd0;
	localparam logic [1:0] HOLD_CLOCK  = 2'd1;
	localparam logic [1:0] HOLD_REPORT = 2'd2;

	// Command codes
	localparam logic [3:0] FN_RDBYTE  = 4'd0;
	localparam logic [3:0] FN_WRBYTE  = 4'd1;
	localparam logic [3:0] FN_BITREAD = 4'd2;
	localparam logic [3:0] FN_PEEK    = 4'd3;
	localparam logic [3:0] FN_TICKS   = 4'd4;
	localparam logic [3:0] FN_CLKHI   = 4'd5;
	localparam logic [3:0] FN_CLKLO   = 4'd6;
	localparam logic [3:0] FN_DATHI   = 4'd7;
	localparam logic [3:0] FN_DATLO   = 4'd8;
	localparam logic [3:0] FN_START   = 4'd9;
	localparam logic [3:0] FN_STARTRD = 4'd10;
	localparam logic [3:0] FN_STOP    = 4'd11;
	localparam logic [3:0] FN_SETUP   = 4'd12;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PUSH_PULL = 1'b1;

	localparam int MAX_TICKS_DEF = 31;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_DATA,
		PH_CLKHI,
		PH_CLKLO
	} phase_t;

endpackage

/* hdl/three_wire_serial_master.sv */
// Channel   Dir  Transfer carries
// s_*       in   one command: func, value, miso_samples
// m_*       out  one pin event: pin states, hold class, read result, error, last
// cfg_*     in   register write: lsb_first, push_pull
//
// A command is taken, then its pin events leave at one per cycle while the
// output side takes them: 25 events for a byte, three for a bit read, 2n for
// ticks (n capped at MAX_TICKS) and one for the rest. Zero ticks yield no event.
// The next command is taken in the cycle after the sequencer produces the last
// event of the previous one, even while that event still waits for the output.
// Reset releases clock and data, drives chip select high, clears config and state.
module three_wire_serial_master
	import tws_pkg::*;
#(
	parameter int MAX_TICKS = MAX_TICKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,  // value[7:0], miso_samples[15:8]
	input  logic [3:0]           s_tuser,  // func[3:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,  // clk_pin[1:0], data_pin[3:2], cs_pin[5:4],
	                                       // hold_class[7:6], read_value[15:8]
	output logic [1:0]           m_tuser,  // read_valid[0], cmd_error[1]
	output logic                 m_tlast
);

	localparam int CntW = ($clog2(2 * MAX_TICKS + 1) > 5) ? $clog2(2 * MAX_TICKS + 1) : 5;
	localparam logic [CntW-1:0] ByteEvents = CntW'(25);
	localparam logic [CntW-1:0] BitEvents = CntW'(3);
	localparam logic [CntW-1:0] OneEvent = CntW'(1);
	localparam logic [7:0] MaxTicks = 8'(MAX_TICKS);

	seq_state_t state_q, state_d;
	phase_t ph_q, ph_next;
	logic [CntW-1:0] rem_q;
	logic [3:0] func_q;
	logic [7:0] tx_q, rx_q, miso_q;
	logic miso0_q, seq_q, byte_q, bit_q, report_q, err_q;
	logic lsb_first_q, push_pull_q, wwr_q;
	logic [1:0] clk_q, data_q, cs_q;
	logic m_tvalid_q, hold_q_valid_unused;
	logic [1:0] hold_q;
	logic [7:0] rdval_q;
	logic rdv_q, err_out_q, last_q;

	logic [3:0] in_func;
	logic [7:0] in_value, in_miso, tick_n;
	logic load, fire, out_free, tx_bit, ev_last;
	logic [1:0] hi_lvl, ev_clk, ev_data, ev_cs, ev_hold;
	logic ev_wwr;

	assign in_func = s_tuser;
	assign in_value = s_tdata[7:0];
	assign in_miso = s_tdata[15:8];
	assign tick_n = (in_value > MaxTicks) ? MaxTicks : in_value;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == SEQ_IDLE);
	assign hi_lvl = push_pull_q ? PIN_HIGH : PIN_REL;
	assign tx_bit = lsb_first_q ? tx_q[0] : tx_q[7];
	assign ev_last = (rem_q == OneEvent);
	assign hold_q_valid_unused = 1'b0;

	always_comb begin
		state_d = state_q;
		load = 1'b0;
		fire = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				if (s_tvalid) begin
					load = 1'b1;
					if (!(in_func == FN_TICKS && tick_n == 8'd0)) begin
						state_d = SEQ_RUN;
					end
				end
			end
			SEQ_RUN: begin
				if (out_free) begin
					fire = 1'b1;
					if (ev_last) begin
						state_d = SEQ_IDLE;
					end
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	// Pin event of the current step
	always_comb begin
		ev_clk = clk_q;
		ev_data = data_q;
		ev_cs = cs_q;
		ev_hold = HOLD_REPORT;
		ev_wwr = wwr_q;
		ph_next = ph_q;
		if (seq_q) begin
			unique case (ph_q)
				PH_DATA: begin
					ev_data = tx_bit ? hi_lvl : PIN_LOW;
					ev_hold = HOLD_SETTLE;
					ph_next = PH_CLKHI;
				end
				PH_CLKHI: begin
					ev_clk = hi_lvl;
					ev_hold = HOLD_CLOCK;
					ph_next = PH_CLKLO;
				end
				PH_CLKLO: begin
					ev_clk = PIN_LOW;
					ev_hold = HOLD_CLOCK;
					ph_next = byte_q ? PH_DATA : PH_CLKHI;
				end
				default: ph_next = PH_CLKLO;
			endcase
		end else begin
			unique case (func_q)
				FN_START, FN_STARTRD: begin
					ev_wwr = (func_q == FN_STARTRD);
					ev_cs = PIN_LOW;
					ev_hold = HOLD_SETTLE;
				end
				FN_STOP: begin
					ev_wwr = 1'b0;
					ev_cs = hi_lvl;
					ev_hold = HOLD_SETTLE;
				end
				FN_SETUP: begin
					ev_wwr = 1'b0;
					ev_clk = PIN_REL;
					ev_data = PIN_REL;
					ev_cs = PIN_HIGH;
				end
				// Peek and unknown codes report with the pins unchanged.
				default: ev_hold = HOLD_REPORT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			lsb_first_q <= 1'b0;
			push_pull_q <= 1'b0;
			wwr_q <= 1'b0;
			clk_q <= PIN_REL;
			data_q <= PIN_REL;
			cs_q <= PIN_HIGH;
			m_tvalid_q <= 1'b0;
			rem_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LSB_FIRST: lsb_first_q <= cfg_data;
					CFG_PUSH_PULL: push_pull_q <= cfg_data;
					default: ;
				endcase
			end
			if (load) begin
				priority if (in_func == FN_RDBYTE || in_func == FN_WRBYTE) begin
					rem_q <= ByteEvents;
				end else if (in_func == FN_BITREAD) begin
					rem_q <= BitEvents;
				end else if (in_func == FN_TICKS) begin
					rem_q <= CntW'({tick_n, 1'b0});
				end else begin
					rem_q <= OneEvent;
				end
			end else if (fire) begin
				rem_q <= rem_q - OneEvent;
			end
			if (fire) begin
				clk_q <= ev_clk;
				data_q <= ev_data;
				cs_q <= ev_cs;
				wwr_q <= ev_wwr;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Command and shift registers
	always_ff @(posedge clk) begin
		if (load) begin
			func_q <= in_func;
			miso_q <= in_miso;
			miso0_q <= in_miso[0];
			rx_q <= 8'h00;
			if (in_func == FN_WRBYTE) begin
				tx_q <= in_value;
			end else if (in_func == FN_DATLO) begin
				tx_q <= 8'h00;
			end else begin
				tx_q <= 8'hff;
			end
			byte_q <= (in_func == FN_RDBYTE || in_func == FN_WRBYTE);
			bit_q <= (in_func == FN_BITREAD || in_func == FN_PEEK);
			seq_q <= (in_func == FN_RDBYTE || in_func == FN_WRBYTE ||
				in_func == FN_BITREAD || in_func == FN_TICKS ||
				in_func == FN_CLKHI || in_func == FN_CLKLO ||
				in_func == FN_DATHI || in_func == FN_DATLO);
			report_q <= (in_func == FN_RDBYTE || in_func == FN_BITREAD ||
				in_func == FN_PEEK || (in_func == FN_WRBYTE && wwr_q));
			err_q <= (in_func > FN_SETUP);
			if (in_func == FN_BITREAD || in_func == FN_DATHI || in_func == FN_DATLO) begin
				ph_q <= PH_DATA;
			end else if (in_func == FN_TICKS || in_func == FN_CLKHI) begin
				ph_q <= PH_CLKHI;
			end else begin
				ph_q <= PH_CLKLO;
			end
		end else if (fire) begin
			ph_q <= ph_next;
			if (seq_q && ph_q == PH_DATA) begin
				tx_q <= lsb_first_q ? {1'b0, tx_q[7:1]} : {tx_q[6:0], 1'b0};
			end
			if (seq_q && ph_q == PH_CLKHI) begin
				miso_q <= {1'b0, miso_q[7:1]};
				rx_q <= lsb_first_q ? {miso_q[0], rx_q[7:1]} : {rx_q[6:0], miso_q[0]};
			end
		end
		if (fire) begin
			hold_q <= ev_hold;
			last_q <= ev_last;
			rdv_q <= ev_last && report_q;
			err_out_q <= ev_last && err_q && !hold_q_valid_unused;
			if (ev_last && report_q) begin
				rdval_q <= bit_q ? {7'b0, miso0_q} : rx_q;
			end else begin
				rdval_q <= 8'h00;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {rdval_q, hold_q, cs_q, data_q, clk_q};
	assign m_tuser = {err_out_q, rdv_q};
	assign m_tlast = last_q;

`ifndef SYNTHESIS
	a_run_has_events: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_RUN) |-> (rem_q != '0))
		else $error("sequencer running with no events left");

	a_stall_holds_event: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
			$stable(m_tuser) && $stable(m_tlast)))
		else $error("pin event changed while the output stalled");

	a_error_is_report: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata[7:6] == HOLD_REPORT && m_tlast && !m_tuser[0]))
		else $error("error event is not a single report event");
`endif

endmodule

/* sim/testbench.sv */
module testbench;
	import tws_pkg::*;

	typedef struct packed {
		logic [3:0] func;
		logic [7:0] value;
		logic [7:0] miso;
	} serial_cmd_t;

	typedef struct packed {
		logic [1:0] clk_pin;
		logic [1:0] data_pin;
		logic [1:0] cs_pin;
		logic [1:0] hold;
		logic [7:0] rd_value;
		logic       rd_valid;
		logic       err;
		logic       last;
	} pin_event_t;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 12;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic                 cfg_data = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;
	logic [3:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;

	serial_cmd_t cmd_backlog[$];
	pin_event_t  pin_events_due[$];

	// Predicted pin and register state
	logic       cfg_lsb = 1'b0;
	logic       cfg_pp = 1'b0;
	logic       wr_with_rd = 1'b0;
	logic [1:0] clk_st = PIN_REL;
	logic [1:0] dat_st = PIN_REL;
	logic [1:0] cs_st = PIN_HIGH;

	logic cmd_accepted = 1'b0;
	logic no_idle = 1'b0;
	int   send_gap = 0;
	int   ready_hold = 0;
	int   idle_cycles = 0;
	int   fail_count = 0;
	int   results_seen = 0;

	three_wire_serial_master u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	function automatic logic [1:0] level_high();
		return cfg_pp ? PIN_HIGH : PIN_REL;
	endfunction

	function automatic void add_event(logic [1:0] hold);
		pin_event_t ev;
		ev.clk_pin = clk_st;
		ev.data_pin = dat_st;
		ev.cs_pin = cs_st;
		ev.hold = hold;
		ev.rd_value = 8'h00;
		ev.rd_valid = 1'b0;
		ev.err = 1'b0;
		ev.last = 1'b0;
		pin_events_due.push_back(ev);
	endfunction

	function automatic void move_clock(logic hi);
		clk_st = hi ? level_high() : PIN_LOW;
		add_event(HOLD_CLOCK);
	endfunction

	function automatic void move_data(logic hi);
		dat_st = hi ? level_high() : PIN_LOW;
		add_event(HOLD_SETTLE);
	endfunction

	function automatic logic [7:0] shift_byte_events(logic [7:0] tx, logic [7:0] miso);
		logic [7:0] rx;
		rx = 8'h00;
		move_clock(1'b0);
		for (int k = 0; k < 8; k++) begin
			move_data(cfg_lsb ? tx[k] : tx[7-k]);
			move_clock(1'b1);
			if (cfg_lsb)
				rx = {miso[k], rx[7:1]};
			else
				rx = {rx[6:0], miso[k]};
			move_clock(1'b0);
		end
		return rx;
	endfunction

	function automatic void predict_pin_events(serial_cmd_t c);
		int         first_idx;
		int         n_ticks;
		logic [7:0] rd;
		logic       report;
		logic       err;
		pin_event_t tail;
		first_idx = pin_events_due.size();
		rd = 8'h00;
		report = 1'b0;
		err = 1'b0;
		case (c.func)
			FN_RDBYTE: begin
				rd = shift_byte_events(8'hFF, c.miso);
				report = 1'b1;
			end
			FN_WRBYTE: begin
				rd = shift_byte_events(c.value, c.miso);
				report = wr_with_rd;
			end
			FN_BITREAD: begin
				move_data(1'b1);
				move_clock(1'b1);
				move_clock(1'b0);
				rd = {7'b0, c.miso[0]};
				report = 1'b1;
			end
			FN_PEEK: begin
				add_event(HOLD_REPORT);
				rd = {7'b0, c.miso[0]};
				report = 1'b1;
			end
			FN_TICKS: begin
				n_ticks = (c.value > MAX_TICKS_DEF) ? MAX_TICKS_DEF : int'(c.value);
				for (int k = 0; k < n_ticks; k++) begin
					move_clock(1'b1);
					move_clock(1'b0);
				end
			end
			FN_CLKHI: move_clock(1'b1);
			FN_CLKLO: move_clock(1'b0);
			FN_DATHI: move_data(1'b1);
			FN_DATLO: move_data(1'b0);
			FN_START, FN_STARTRD: begin
				wr_with_rd = (c.func == FN_STARTRD);
				cs_st = PIN_LOW;
				add_event(HOLD_SETTLE);
			end
			FN_STOP: begin
				wr_with_rd = 1'b0;
				cs_st = level_high();
				add_event(HOLD_SETTLE);
			end
			FN_SETUP: begin
				wr_with_rd = 1'b0;
				clk_st = PIN_REL;
				dat_st = PIN_REL;
				cs_st = PIN_HIGH;
				add_event(HOLD_REPORT);
			end
			default: begin
				add_event(HOLD_REPORT);
				err = 1'b1;
			end
		endcase
		if (pin_events_due.size() > first_idx) begin
			tail = pin_events_due.pop_back();
			tail.rd_value = report ? rd : 8'h00;
			tail.rd_valid = report;
			tail.err = err;
			tail.last = 1'b1;
			pin_events_due.push_back(tail);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 30);
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("mismatch in result %0d, %s: got %0h, expected %0h",
			results_seen, what, got, want);
		fail_count++;
	endtask

	// Prediction, result checking and the watchdog
	always @(posedge clk) begin
		pin_event_t want;
		pin_event_t got;
		serial_cmd_t c;
		cmd_accepted = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LSB_FIRST: cfg_lsb = cfg_data;
					CFG_PUSH_PULL: cfg_pp = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				cmd_accepted = 1'b1;
				c.func = s_tuser;
				c.value = s_tdata[7:0];
				c.miso = s_tdata[15:8];
				predict_pin_events(c);
			end
			if (m_tvalid && m_tready) begin
				got.clk_pin = m_tdata[1:0];
				got.data_pin = m_tdata[3:2];
				got.cs_pin = m_tdata[5:4];
				got.hold = m_tdata[7:6];
				got.rd_value = m_tdata[15:8];
				got.rd_valid = m_tuser[0];
				got.err = m_tuser[1];
				got.last = m_tlast;
				if (pin_events_due.size() == 0) begin
					report_mismatch("unexpected transfer", m_tdata[7:0], 8'h00);
				end else begin
					want = pin_events_due.pop_front();
					if (got.clk_pin !== want.clk_pin)
						report_mismatch("clk_pin", 8'(got.clk_pin), 8'(want.clk_pin));
					if (got.data_pin !== want.data_pin)
						report_mismatch("data_pin", 8'(got.data_pin), 8'(want.data_pin));
					if (got.cs_pin !== want.cs_pin)
						report_mismatch("cs_pin", 8'(got.cs_pin), 8'(want.cs_pin));
					if (got.hold !== want.hold)
						report_mismatch("hold_class", 8'(got.hold), 8'(want.hold));
					if (got.rd_value !== want.rd_value)
						report_mismatch("read_value", got.rd_value, want.rd_value);
					if (got.rd_valid !== want.rd_valid)
						report_mismatch("read_valid", 8'(got.rd_valid), 8'(want.rd_valid));
					if (got.err !== want.err)
						report_mismatch("cmd_error", 8'(got.err), 8'(want.err));
					if (got.last !== want.last)
						report_mismatch("last", 8'(got.last), 8'(want.last));
				end
				results_seen++;
			end
			if (cmd_accepted || (m_tvalid && m_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired with %0d results outstanding",
					pin_events_due.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Command driver
	always @(negedge clk) begin
		serial_cmd_t c;
		if (arst_n) begin
			if (cmd_accepted)
				send_gap = pick_gap();
			if (!s_tvalid || cmd_accepted) begin
				if (send_gap != 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					c = cmd_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {c.miso, c.value};
					s_tuser <= c.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result receiver with random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (ready_hold == 0 && $urandom_range(0, 99) < 25)
				ready_hold = pick_gap();
			m_tready <= (ready_hold == 0);
			if (ready_hold != 0)
				ready_hold--;
		end
	end

	task automatic push_cmd(logic [3:0] func, logic [7:0] value, logic [7:0] miso);
		serial_cmd_t c;
		c.func = func;
		c.value = value;
		c.miso = miso;
		cmd_backlog.push_back(c);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every command is taken and every pin event has arrived,
	// then lets the block settle, since a zero tick count yields no transfer.
	task automatic wait_drained();
		@(posedge clk);
		while (cmd_backlog.size() != 0 || s_tvalid || pin_events_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] tick_count();
		return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 6))
			: 8'($urandom_range(0, 255));
	endfunction

	// Mostly framed transactions with random content, plus loose commands.
	task automatic add_random_cmds(int count);
		int         added;
		int         n_ops;
		logic [3:0] op;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 99) < 70) begin
				push_cmd($urandom_range(0, 1) ? FN_STARTRD : FN_START,
					8'($urandom), 8'($urandom));
				n_ops = $urandom_range(1, 4);
				for (int k = 0; k < n_ops; k++) begin
					case ($urandom_range(0, 9))
						0, 1, 2: op = FN_RDBYTE;
						3, 4, 5, 6: op = FN_WRBYTE;
						7: op = FN_BITREAD;
						8: op = FN_PEEK;
						default: op = FN_TICKS;
					endcase
					push_cmd(op, (op == FN_TICKS) ? tick_count() : 8'($urandom),
						8'($urandom));
				end
				added += n_ops + 1;
				if ($urandom_range(0, 9) != 0) begin
					push_cmd(FN_STOP, 8'($urandom), 8'($urandom));
					added++;
				end
			end else begin
				op = 4'($urandom_range(0, 15));
				push_cmd(op, (op == FN_TICKS) ? tick_count() : 8'($urandom),
					8'($urandom));
				added++;
			end
		end
	endtask

	initial begin
		logic [1:0] phase_cfg[6];
		phase_cfg = '{2'b01, 2'b10, 2'b11, 2'b00, 2'b11, 2'b01};
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed commands with the registers at their reset values
		push_cmd(FN_SETUP, 8'h00, 8'h00);
		push_cmd(FN_START, 8'h00, 8'h00);
		push_cmd(FN_WRBYTE, 8'h00, 8'hFF);
		push_cmd(FN_WRBYTE, 8'hFF, 8'h00);
		push_cmd(FN_STARTRD, 8'h00, 8'h00);
		push_cmd(FN_WRBYTE, 8'hA5, 8'h3C);
		push_cmd(FN_RDBYTE, 8'h00, 8'hFF);
		push_cmd(FN_RDBYTE, 8'hFF, 8'h00);
		push_cmd(FN_RDBYTE, 8'h5A, 8'h81);
		push_cmd(FN_BITREAD, 8'h00, 8'h01);
		push_cmd(FN_BITREAD, 8'hFF, 8'hFE);
		push_cmd(FN_PEEK, 8'h00, 8'hFF);
		push_cmd(FN_PEEK, 8'hFF, 8'h00);
		push_cmd(FN_TICKS, 8'd0, 8'h00);
		push_cmd(FN_TICKS, 8'd1, 8'h00);
		push_cmd(FN_TICKS, 8'd31, 8'h00);
		push_cmd(FN_TICKS, 8'd32, 8'h00);
		push_cmd(FN_TICKS, 8'd255, 8'hFF);
		push_cmd(FN_CLKHI, 8'h00, 8'h00);
		push_cmd(FN_CLKLO, 8'h00, 8'h00);
		push_cmd(FN_DATHI, 8'h00, 8'h00);
		push_cmd(FN_DATLO, 8'h00, 8'h00);
		push_cmd(FN_STOP, 8'h00, 8'h00);
		push_cmd(4'd13, 8'hFF, 8'hFF);
		push_cmd(4'd15, 8'h00, 8'h00);
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			no_idle = (p == 2);
			write_cfg(CFG_LSB_FIRST, phase_cfg[p][0]);
			write_cfg(CFG_PUSH_PULL, phase_cfg[p][1]);
			add_random_cmds(40);
			wait_drained();
		end

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
